// ===== design/fdsc_pkg.sv =====
package fdsc_pkg;

  // Framing bytes
  localparam logic [7:0] FLAG_BYTE = 8'h7E;  // '~'
  localparam logic [7:0] SEP_BYTE  = 8'h3E;  // '>'

  // Field numbers
  localparam logic [2:0] CMD_FIELD   = 3'd5;
  localparam logic [2:0] CHECK_FIELD = 3'd6;
  localparam logic [2:0] FIELD_MAX   = 3'd7;
  localparam logic [6:0] POS_MAX     = 7'd127;
  localparam logic [1:0] SEEN_MAX    = 2'd2;

  // Result status codes
  typedef enum logic [1:0] {
    ST_CMD   = 2'd0,
    ST_EMPTY = 2'd1,
    ST_ERR   = 2'd2
  } status_t;

endpackage

// ===== design/fdsc_ram.sv =====
module fdsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/flag_deframer_sum_check_top.sv =====
// Flag-delimited frame receiver with a 16-bit additive check. Takes one
// received byte per item; a '~' opens a frame and the next '~' closes it,
// '>' separates fields, field 5 is the command (up to COMMAND_DEPTH bytes,
// further ones dropped) and the first two bytes of field 6 are the check
// high and low bytes. The sum covers every frame byte but the last two.
// Bytes inside a frame are taken one per cycle while in_stall is low and
// give no result. The closing flag gives either one error item (check
// mismatch), one status item (good frame, empty command) or the stored
// command, one byte per item with out_last on the final one. The command is
// replayed from a RAM with a registered read: S_READ issues the first read,
// then S_EMIT moves one item per cycle while out_stall is low. A closing flag
// holds in_stall high through S_READ and S_EMIT. Input also stalls while the
// output register holds an item that is itself stalled.
module flag_deframer_sum_check_top #(
  parameter int COMMAND_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] out_frame_status,
  output logic       out_last
);
  import fdsc_pkg::*;

  localparam int AW = (COMMAND_DEPTH > 1) ? $clog2(COMMAND_DEPTH) : 1;
  localparam int LW = $clog2(COMMAND_DEPTH + 1);

  typedef enum logic [1:0] {
    S_RUN,   // take bytes
    S_READ,  // first command read in flight
    S_EMIT   // move command bytes into the output register
  } state_t;

  state_t        state_r, state_nxt;
  logic          in_frame_r, in_frame_nxt;
  logic [2:0]    field_idx_r, field_idx_nxt;
  logic [6:0]    field_pos_r, field_pos_nxt;
  logic [15:0]   sum_r, sum_nxt;
  logic [7:0]    dly_one_r, dly_one_nxt;
  logic [7:0]    dly_two_r, dly_two_nxt;
  logic [1:0]    seen_r, seen_nxt;
  logic [7:0]    chk_hi_r, chk_hi_nxt;
  logic [7:0]    chk_lo_r, chk_lo_nxt;
  logic [LW-1:0] cmd_len_r, cmd_len_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  status_t       out_status_r, out_status_nxt;
  logic          out_last_r, out_last_nxt;

  logic          in_acc;
  logic          out_free;
  logic          sum_ok;
  logic          dump_last;
  logic          wr_en;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  fdsc_ram #(
    .WIDTH (8),
    .DEPTH (COMMAND_DEPTH)
  ) u_cmd_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cmd_len_r[AW-1:0]),
    .wr_data (in_rx_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The output register is free if empty or being emptied this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_RUN) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign sum_ok   = (sum_r == {chk_hi_r, chk_lo_r});
  assign dump_last = ((LW'(ptr_r) + LW'(1)) == cmd_len_r);

  always_comb begin
    state_nxt      = state_r;
    in_frame_nxt   = in_frame_r;
    field_idx_nxt  = field_idx_r;
    field_pos_nxt  = field_pos_r;
    sum_nxt        = sum_r;
    dly_one_nxt    = dly_one_r;
    dly_two_nxt    = dly_two_r;
    seen_nxt       = seen_r;
    chk_hi_nxt     = chk_hi_r;
    chk_lo_nxt     = chk_lo_r;
    cmd_len_nxt    = cmd_len_r;
    ptr_nxt        = ptr_r;
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = ptr_r;

    // Drop the held item once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_RUN: begin
        if (in_acc) begin
          if (!in_frame_r) begin
            // Outside a frame only an opening flag matters
            if (in_rx_byte == FLAG_BYTE) begin
              in_frame_nxt = 1'b1;
            end
          end else if (in_rx_byte == FLAG_BYTE) begin
            // Closing flag: judge the frame and reset per-frame state
            in_frame_nxt  = 1'b0;
            field_idx_nxt = '0;
            field_pos_nxt = '0;
            sum_nxt       = '0;
            dly_one_nxt   = '0;
            dly_two_nxt   = '0;
            seen_nxt      = '0;
            if (!sum_ok) begin
              out_valid_nxt  = 1'b1;
              out_byte_nxt   = '0;
              out_status_nxt = ST_ERR;
              out_last_nxt   = 1'b1;
              cmd_len_nxt    = '0;
            end else if (cmd_len_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_byte_nxt   = '0;
              out_status_nxt = ST_EMPTY;
              out_last_nxt   = 1'b1;
            end else begin
              // Keep the length until the dump is over
              ptr_nxt   = '0;
              state_nxt = S_READ;
            end
          end else begin
            // A byte joins the sum once two more bytes follow it
            if (seen_r == SEEN_MAX) begin
              sum_nxt = sum_r + 16'(dly_two_r);
            end else begin
              seen_nxt = seen_r + 2'd1;
            end
            dly_two_nxt = dly_one_r;
            dly_one_nxt = in_rx_byte;

            if (in_rx_byte == SEP_BYTE) begin
              if (field_idx_r != FIELD_MAX) begin
                field_idx_nxt = field_idx_r + 3'd1;
              end
              field_pos_nxt = '0;
            end else begin
              if (field_idx_r == CMD_FIELD) begin
                if (cmd_len_r < LW'(COMMAND_DEPTH)) begin
                  wr_en       = 1'b1;
                  cmd_len_nxt = cmd_len_r + LW'(1);
                end
              end else if (field_idx_r == CHECK_FIELD) begin
                if (field_pos_r == 7'd0) begin
                  chk_hi_nxt = in_rx_byte;
                end else if (field_pos_r == 7'd1) begin
                  chk_lo_nxt = in_rx_byte;
                end
              end
              if (field_pos_r != POS_MAX) begin
                field_pos_nxt = field_pos_r + 7'd1;
              end
            end
          end
        end
      end

      S_READ: begin
        rd_en     = 1'b1;
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = rd_data;
          out_status_nxt = ST_CMD;
          out_last_nxt   = dump_last;
          if (dump_last) begin
            cmd_len_nxt = '0;
            state_nxt   = S_RUN;
          end else begin
            // Advance and fetch the next byte behind this one
            ptr_nxt = ptr_r + AW'(1);
            rd_en   = 1'b1;
            rd_addr = ptr_nxt;
          end
        end
      end

      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      in_frame_r  <= 1'b0;
      field_idx_r <= '0;
      field_pos_r <= '0;
      sum_r       <= '0;
      dly_one_r   <= '0;
      dly_two_r   <= '0;
      seen_r      <= '0;
      chk_hi_r    <= '0;
      chk_lo_r    <= '0;
      cmd_len_r   <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_frame_r  <= in_frame_nxt;
      field_idx_r <= field_idx_nxt;
      field_pos_r <= field_pos_nxt;
      sum_r       <= sum_nxt;
      dly_one_r   <= dly_one_nxt;
      dly_two_r   <= dly_two_nxt;
      seen_r      <= seen_nxt;
      chk_hi_r    <= chk_hi_nxt;
      chk_lo_r    <= chk_lo_nxt;
      cmd_len_r   <= cmd_len_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_byte_r   <= out_byte_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_frame_status = out_status_r;
  assign out_last         = out_last_r;

`ifndef SYNTHESIS
  // A command dump runs without gaps until its last item
  a_dump_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("gap inside command dump");

  // Status and error items always close their frame
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_frame_status != ST_CMD) |-> out_last)
    else $error("status item without last");

  // The command store is never written while it is being replayed
  a_no_write_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_RUN) |-> !wr_en)
    else $error("command write during dump");
`endif

endmodule
